/* sv/ktc_pkg.sv */
// shared types, constants and helper functions of the tag counter
package ktc_pkg;

  localparam int MAX_TAG       = 8;
  // table depth, a power of two so that the slot wraps by truncation
  localparam int TABLE_ENTRIES = 4096;

  localparam int KEY_W  = MAX_TAG * 8;
  localparam int FILL_W = $clog2(MAX_TAG + 1);
  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int DIST_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CNT_W  = 32;
  localparam int LEN_W  = 4;
  localparam int UNIQ_W = 13;

  localparam logic [LEN_W-1:0] TAG_LEN_RST = LEN_W'(3);

  // multiplicative hash, folded by xor of its low bits with the bits above a right shift
  localparam int          HASH_SHIFT = 29;
  localparam int          HASH_W     = HASH_SHIFT + IDX_W;
  localparam int          HASH_LO_W  = 32;
  localparam int          HASH_HI_W  = HASH_W - HASH_LO_W;
  localparam logic [63:0] HASH_MULT  = 64'h9E37_79B9_7F4A_7C15;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic             valid;
    key_t             key;
    logic [CNT_W-1:0] count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [7:0] residue;
    logic       last_in_line;
  } in_req_t;

  typedef struct packed {
    logic              tag_formed;
    logic [CNT_W-1:0]  tag_count;
    logic              line_report;
    logic [UNIQ_W-1:0] unique_tags;
    logic [CNT_W-1:0]  max_repeat;
    logic [CNT_W-1:0]  samples_taken;
    logic              table_overflow;
  } out_res_t;

  function automatic logic [FILL_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [FILL_W-1:0] k;
    if (len == '0) begin
      k = FILL_W'(1);
    end else if (int'(len) > MAX_TAG) begin
      k = FILL_W'(MAX_TAG);
    end else begin
      k = FILL_W'(len);
    end
    return k;
  endfunction

  function automatic key_t key_mask(input logic [FILL_W-1:0] k);
    key_t m;
    m = '0;
    for (int i = 0; i < MAX_TAG; i++) begin
      if (i < int'(k)) begin
        m[i*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

endpackage

/* sv/ktc_ram.sv */
// generic single write port ram with registered read
module ktc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/ktc_hash.sv */
// two-step multiplicative hash of a tag key to a table slot
module ktc_hash (
  input  logic          clk,
  input  ktc_pkg::key_t key,
  output ktc_pkg::idx_t idx
);
  import ktc_pkg::*;

  logic [63:0]            key_ext;
  logic [HASH_LO_W-1:0]   a0;
  logic [HASH_LO_W-1:0]   c0;
  logic [HASH_HI_W-1:0]   a1;
  logic [HASH_HI_W-1:0]   c1;
  logic [2*HASH_HI_W-1:0] cross_a;
  logic [2*HASH_HI_W-1:0] cross_b;
  logic [HASH_HI_W-1:0]   cross_nxt;
  logic [2*HASH_LO_W-1:0] prod_lo_r;
  logic [HASH_HI_W-1:0]   cross_r;
  logic [HASH_HI_W-1:0]   h_hi;
  logic [HASH_W-1:0]      h;

  assign key_ext = 64'(key);
  assign a0      = key_ext[HASH_LO_W-1:0];
  assign a1      = key_ext[HASH_W-1:HASH_LO_W];
  assign c0      = HASH_MULT[HASH_LO_W-1:0];
  assign c1      = HASH_MULT[HASH_W-1:HASH_LO_W];

  // only the low bits of the cross products reach the used product bits
  assign cross_a   = a0[HASH_HI_W-1:0] * c1;
  assign cross_b   = a1 * c0[HASH_HI_W-1:0];
  assign cross_nxt = cross_a[HASH_HI_W-1:0] + cross_b[HASH_HI_W-1:0];

  always_ff @(posedge clk) begin
    prod_lo_r <= a0 * c0;
    cross_r   <= cross_nxt;
  end

  assign h_hi = cross_r + prod_lo_r[HASH_W-1:HASH_LO_W];
  assign h    = {h_hi, prod_lo_r[HASH_LO_W-1:0]};
  assign idx  = h[IDX_W-1:0] ^ h[HASH_W-1:HASH_SHIFT];

endmodule

/* sv/kmer_tag_counter.sv */
// top level of the tag counter: byte window, probe sequencer and running totals
// sequence: a byte that forms no tag goes from idle straight to the result stage; a formed
//   tag passes the hash states, a table read and a check, and each further probe repeats read and check
// flow: one request at a time, the next is taken once the result is staged,
//   which a stalled output holds off
// reset: synchronous active-low; a clearing pass over all 4096 slots empties the table first
module kmer_tag_counter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ktc_pkg::in_req_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ktc_pkg::out_res_t          out_data,
  input  logic                       cfg_wr_en,
  input  logic [ktc_pkg::LEN_W-1:0]  cfg_wr_data
);
  import ktc_pkg::*;

  typedef enum logic [6:0] {
    S_CLR   = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_HASH1 = 7'b0000100,
    S_HASH2 = 7'b0001000,
    S_RD    = 7'b0010000,
    S_CHK   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  // sequencer and control
  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  tag_len_r;
  idx_t              clr_r, clr_nxt;
  idx_t              probe_r, probe_nxt;

  // window of the current line, newest byte in the low byte
  key_t              win_r, win_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  // request in flight
  key_t              key_r, key_nxt;
  idx_t              idx_r, idx_nxt;
  logic              formed_r, formed_nxt;
  logic              report_r, report_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  // running totals
  logic [DIST_W-1:0] distinct_r, distinct_nxt;
  logic [CNT_W-1:0]  highest_r, highest_nxt;
  logic [CNT_W-1:0]  samples_r, samples_nxt;
  logic              overflow_r, overflow_nxt;

  // result stage
  logic              out_valid_r, out_valid_nxt;
  out_res_t          out_data_r, out_data_nxt;
  logic              out_load;

  // window arithmetic for the incoming byte
  key_t              win_shift;
  logic [FILL_W-1:0] fill_inc;
  logic [FILL_W-1:0] k_eff;
  logic              formed_now;
  key_t              key_now;

  // table access
  idx_t              hash_idx;
  logic              ram_we;
  idx_t              ram_waddr;
  entry_t            ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd_entry;
  logic [CNT_W-1:0]  cnt_inc;

  ktc_hash u_hash (
    .clk (clk),
    .key (key_r),
    .idx (hash_idx)
  );

  // key, count and valid flag share one word per slot
  ktc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (idx_r),
    .rd_data (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);
  assign cnt_inc  = sat_inc(rd_entry.count);

  // a request is only taken while the sequencer waits in idle
  assign in_stall = (state_r != S_IDLE);

  assign win_shift  = (win_r << 8) | KEY_W'(in_data.residue);
  assign fill_inc   = (fill_r == FILL_W'(MAX_TAG)) ? fill_r : fill_r + FILL_W'(1);
  // a length change takes effect at once, on whatever the window holds
  assign k_eff      = eff_len(tag_len_r);
  assign formed_now = (fill_inc >= k_eff);
  assign key_now    = win_shift & key_mask(k_eff);

  // result stage frees itself when the downstream side takes it
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    probe_nxt    = probe_r;
    win_nxt      = win_r;
    fill_nxt     = fill_r;
    key_nxt      = key_r;
    idx_nxt      = idx_r;
    formed_nxt   = formed_r;
    report_nxt   = report_r;
    count_nxt    = count_r;
    distinct_nxt = distinct_r;
    highest_nxt  = highest_r;
    samples_nxt  = samples_r;
    overflow_nxt = overflow_r;
    ram_we       = 1'b0;
    ram_waddr    = idx_r;
    ram_wdata    = '0;

    unique case (state_r)
      S_CLR: begin
        // one slot per cycle back to the empty state
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          key_nxt    = key_now;
          formed_nxt = formed_now;
          report_nxt = formed_now && in_data.last_in_line;
          count_nxt  = '0;
          probe_nxt  = '0;
          // the window empties at the end of every line, short or not
          if (in_data.last_in_line) begin
            win_nxt  = '0;
            fill_nxt = '0;
          end else begin
            win_nxt  = win_shift;
            fill_nxt = fill_inc;
          end
          if (formed_now) begin
            samples_nxt = sat_inc(samples_r);
            state_nxt   = S_HASH1;
          end else begin
            state_nxt   = S_DONE;
          end
        end
      end
      S_HASH1: begin
        // multiplier partial products settle in the hash unit
        state_nxt = S_HASH2;
      end
      S_HASH2: begin
        idx_nxt   = hash_idx;
        state_nxt = S_RD;
      end
      S_RD: begin
        // slot word is read out at this edge
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!rd_entry.valid) begin
          // empty slot: insert the new tag
          ram_we          = 1'b1;
          ram_wdata.valid = 1'b1;
          ram_wdata.key   = key_r;
          ram_wdata.count = CNT_W'(1);
          distinct_nxt    = distinct_r + DIST_W'(1);
          count_nxt       = CNT_W'(1);
          state_nxt       = S_DONE;
        end else if (rd_entry.key == key_r) begin
          // known tag: bump its count and track the highest repeat
          ram_we          = 1'b1;
          ram_wdata.valid = 1'b1;
          ram_wdata.key   = key_r;
          ram_wdata.count = cnt_inc;
          count_nxt       = cnt_inc;
          if (cnt_inc > highest_r) begin
            highest_nxt = cnt_inc;
          end
          state_nxt = S_DONE;
        end else if (probe_r == IDX_W'(TABLE_ENTRIES - 1)) begin
          // every slot visited and taken: tag cannot be stored
          overflow_nxt = 1'b1;
          count_nxt    = '0;
          state_nxt    = S_DONE;
        end else begin
          // linear probing, wraps at the table end
          idx_nxt   = idx_r + IDX_W'(1);
          probe_nxt = probe_r + IDX_W'(1);
          state_nxt = S_RD;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_data_nxt = out_data_r;
    if (out_load) begin
      out_data_nxt.tag_formed     = formed_r;
      out_data_nxt.tag_count      = count_r;
      out_data_nxt.line_report    = report_r;
      out_data_nxt.unique_tags    = UNIQ_W'(distinct_r);
      out_data_nxt.max_repeat     = highest_r;
      out_data_nxt.samples_taken  = samples_r;
      out_data_nxt.table_overflow = overflow_r;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      probe_r     <= '0;
      tag_len_r   <= TAG_LEN_RST;
      win_r       <= '0;
      fill_r      <= '0;
      distinct_r  <= '0;
      highest_r   <= '0;
      samples_r   <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      probe_r     <= probe_nxt;
      win_r       <= win_nxt;
      fill_r      <= fill_nxt;
      distinct_r  <= distinct_nxt;
      highest_r   <= highest_nxt;
      samples_r   <= samples_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
      // register writes are taken at any time, also during the clearing pass
      if (cfg_wr_en) begin
        tag_len_r <= cfg_wr_data;
      end
    end
  end

  // payload of the request in flight and of the result stage
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    idx_r      <= idx_nxt;
    formed_r   <= formed_nxt;
    report_r   <= report_nxt;
    count_r    <= count_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/ktc_checker.sv */
// port-level checks of the tag counter and their binding to the top level
module ktc_port_props (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input ktc_pkg::out_res_t out_data
);
  import ktc_pkg::*;

  // one request at a time: busy straight after a request is taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while previous one still in work");

  // no count without a formed tag
  a_count_needs_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.tag_formed) |-> (out_data.tag_count == '0))
    else $error("tag count reported for a byte that formed no tag");

  // a line report only comes with a formed tag
  a_report_needs_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.line_report) |-> out_data.tag_formed)
    else $error("line report without a formed tag");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or dropped");

endmodule

bind kmer_tag_counter ktc_port_props u_ktc_checker (.*);
